// ----- rtl/core/finite_wait_single_server_queue_assert.svh -----
// assertion macros for the single-server queue
`ifndef FINITE_WAIT_SINGLE_SERVER_QUEUE_ASSERT_SVH
`define FINITE_WAIT_SINGLE_SERVER_QUEUE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define FWSQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fwsq assertion failed");
// next-cycle implication, checked out of reset
`define FWSQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fwsq assertion failed");
`else
`define FWSQ_ASSERT_NOW(lbl, ante, cons)
`define FWSQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/fwsq_pkg.sv -----
`default_nettype none

package fwsq_pkg;

    // waiting area geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;

    // field widths
    localparam int TIME_W = 32;
    localparam int ID_W   = 16;
    localparam int SVC_W  = 16;
    localparam int KIND_W = 3;
    localparam int CFG_W  = 5;
    localparam int CAP_W  = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    // capacity after reset
    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(4);

    // input action codes
    localparam logic ACT_ARRIVE  = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_DROP  = 3'd0,
        KIND_START = 3'd1,
        KIND_WAIT  = 3'd2,
        KIND_IDLE  = 3'd3,
        KIND_NEXT  = 3'd4
    } t_kind;

    // control states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/core/finite_wait_single_server_queue.sv -----
// the first result word is registered from the run state that follows acceptance of the input word
// an input word is taken only in the idle state; the sequencer then retires due finishes,
//   one per cycle while the result register is free; each retire reads the waiting store once
// output stalls hold the sequencer until the result register frees up
// reset: synchronous active low, clears server and queue control, capacity to 4;
//   the waiting store itself is not cleared
`default_nettype none

`include "finite_wait_single_server_queue_assert.svh"

module finite_wait_single_server_queue (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [fwsq_pkg::CFG_W-1:0]     i_cfg_waiting_capacity,
    // input words
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_action,
    input  wire logic [fwsq_pkg::TIME_W-1:0]    i_event_time,
    input  wire logic [fwsq_pkg::ID_W-1:0]      i_customer_id,
    input  wire logic [fwsq_pkg::SVC_W-1:0]     i_service_time,
    // result words
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [fwsq_pkg::KIND_W-1:0]         o_event_kind,
    output logic [fwsq_pkg::TIME_W-1:0]         o_at_time,
    output logic [fwsq_pkg::ID_W-1:0]           o_subject_id,
    output logic [fwsq_pkg::ID_W-1:0]           o_next_id,
    output logic                                o_last
);

    localparam int ADDR_W = fwsq_pkg::ADDR_W;
    localparam int CNT_W  = fwsq_pkg::CNT_W;
    localparam int SUM_W  = fwsq_pkg::SUM_W;
    localparam int CAP_W  = fwsq_pkg::CAP_W;
    localparam int TIME_W = fwsq_pkg::TIME_W;
    localparam int ID_W   = fwsq_pkg::ID_W;
    localparam int SVC_W  = fwsq_pkg::SVC_W;
    localparam int ENT_W  = ID_W + SVC_W;

    // saturating finish time
    function automatic logic [TIME_W-1:0] f_sat_add(input logic [TIME_W-1:0] a,
                                                     input logic [SVC_W-1:0]  b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + (TIME_W + 1)'(b);
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

    // control state
    fwsq_pkg::t_state          r_state, n_state;
    logic [fwsq_pkg::CFG_W-1:0] r_cap;
    logic                      r_busy, n_busy;
    logic [ID_W-1:0]           r_serving, n_serving;
    logic [TIME_W-1:0]         r_finish, n_finish;
    logic [ADDR_W-1:0]         r_head, n_head;
    logic [CNT_W-1:0]          r_count, n_count;

    // latched input word
    logic                      r_action;
    logic [TIME_W-1:0]         r_t;
    logic [ID_W-1:0]           r_cid;
    logic [SVC_W-1:0]          r_svc;

    // result register
    logic                      r_out_valid, n_out_valid;
    fwsq_pkg::t_kind           r_out_kind, n_out_kind;
    logic [TIME_W-1:0]         r_out_time, n_out_time;
    logic [ID_W-1:0]           r_out_subj, n_out_subj;
    logic [ID_W-1:0]           r_out_next, n_out_next;
    logic                      r_out_last, n_out_last;

    // waiting store, one synchronous read port at the head
    logic [ENT_W-1:0]          r_wait_mem [fwsq_pkg::QUEUE_DEPTH];
    logic [ENT_W-1:0]          r_rd_data;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;

    logic                      in_fire;
    logic                      out_free;
    logic                      load;
    logic                      due;
    logic                      room;
    logic [CAP_W-1:0]          cap_ext;
    logic [CAP_W-1:0]          cap_eff;
    logic [SUM_W-1:0]          tail_sum;
    logic [ADDR_W-1:0]         head_inc;
    logic [TIME_W-1:0]         next_finish;
    logic [ID_W-1:0]           head_id;
    logic [SVC_W-1:0]          head_svc;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == fwsq_pkg::ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // effective capacity, clamped to the store depth
    always_comb begin
        cap_ext = CAP_W'(r_cap);
        cap_eff = (cap_ext > CAP_W'(fwsq_pkg::QUEUE_DEPTH))
                  ? CAP_W'(fwsq_pkg::QUEUE_DEPTH) : cap_ext;
        room    = CAP_W'(r_count) < cap_eff;
    end

    // head and tail pointers with wrap at the depth
    always_comb begin
        head_inc = (r_head == ADDR_W'(fwsq_pkg::QUEUE_DEPTH - 1))
                   ? '0 : r_head + ADDR_W'(1);
        tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
        if (tail_sum >= SUM_W'(fwsq_pkg::QUEUE_DEPTH)) begin
            tail_sum = tail_sum - SUM_W'(fwsq_pkg::QUEUE_DEPTH);
        end
        mem_waddr = tail_sum[ADDR_W-1:0];
    end

    // retire test and the head waiter's finish time
    assign due         = r_busy && (r_finish <= r_t);
    assign head_id     = r_rd_data[ENT_W-1:SVC_W];
    assign head_svc    = r_rd_data[SVC_W-1:0];
    assign next_finish = f_sat_add(r_finish, head_svc);

    // sequencer: retire due finishes one a cycle while output is free, then handle the arrival
    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        n_serving   = r_serving;
        n_finish    = r_finish;
        n_head      = r_head;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_kind  = r_out_kind;
        n_out_time  = r_out_time;
        n_out_subj  = r_out_subj;
        n_out_next  = r_out_next;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        load        = 1'b0;

        unique case (r_state)
            fwsq_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = fwsq_pkg::ST_RUN;
                end
            end
            fwsq_pkg::ST_RUN: begin
                if (out_free) begin
                    priority if (due && (r_count == '0)) begin
                        // finish, server goes idle
                        load       = 1'b1;
                        n_out_kind = fwsq_pkg::KIND_IDLE;
                        n_out_time = r_finish;
                        n_out_subj = r_serving;
                        n_out_next = '0;
                        n_out_last = (r_action == fwsq_pkg::ACT_ADVANCE);
                        n_busy     = 1'b0;
                        if (r_action == fwsq_pkg::ACT_ADVANCE) begin
                            n_state = fwsq_pkg::ST_IDLE;
                        end
                    end else if (due) begin
                        // finish, head waiter starts
                        load       = 1'b1;
                        n_out_kind = fwsq_pkg::KIND_NEXT;
                        n_out_time = r_finish;
                        n_out_subj = r_serving;
                        n_out_next = head_id;
                        n_out_last = (r_action == fwsq_pkg::ACT_ADVANCE) &&
                                     !(next_finish <= r_t);
                        n_serving  = head_id;
                        n_finish   = next_finish;
                        n_head     = head_inc;
                        n_count    = r_count - CNT_W'(1);
                        if (n_out_last) begin
                            n_state = fwsq_pkg::ST_IDLE;
                        end
                    end else if (r_action == fwsq_pkg::ACT_ARRIVE) begin
                        load       = 1'b1;
                        n_out_time = r_t;
                        n_out_subj = r_cid;
                        n_out_next = '0;
                        n_out_last = 1'b1;
                        n_state    = fwsq_pkg::ST_IDLE;
                        priority if (!r_busy) begin
                            n_out_kind = fwsq_pkg::KIND_START;
                            n_busy     = 1'b1;
                            n_serving  = r_cid;
                            n_finish   = f_sat_add(r_t, r_svc);
                        end else if (room) begin
                            n_out_kind = fwsq_pkg::KIND_WAIT;
                            mem_we     = 1'b1;
                            n_count    = r_count + CNT_W'(1);
                        end else begin
                            n_out_kind = fwsq_pkg::KIND_DROP;
                        end
                    end else begin
                        // advance with nothing due
                        n_state = fwsq_pkg::ST_IDLE;
                    end
                end
                if (load) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = fwsq_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fwsq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= fwsq_pkg::CAP_RESET;
            r_busy      <= 1'b0;
            r_serving   <= '0;
            r_finish    <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_waiting_capacity;
            end
            r_busy      <= n_busy;
            r_serving   <= n_serving;
            r_finish    <= n_finish;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // input word and result payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_action <= i_action;
            r_t      <= i_event_time;
            r_cid    <= i_customer_id;
            r_svc    <= i_service_time;
        end
        r_out_kind <= n_out_kind;
        r_out_time <= n_out_time;
        r_out_subj <= n_out_subj;
        r_out_next <= n_out_next;
        r_out_last <= n_out_last;
    end

    // waiting store: write at the tail, read at the next head
    // a tail write is always followed by the idle state before the next head read is used,
    // so no forwarding path is needed
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_wait_mem[mem_waddr] <= {r_cid, r_svc};
        end
        r_rd_data <= r_wait_mem[n_head];
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_out_kind;
    assign o_at_time    = r_out_time;
    assign o_subject_id = r_out_subj;
    assign o_next_id    = r_out_next;
    assign o_last       = r_out_last;

    // checks
    `FWSQ_ASSERT_NOW(a_waiters_need_server, r_count != '0, r_busy)
    `FWSQ_ASSERT_NOW(a_count_in_range, 1'b1, CAP_W'(r_count) <= CAP_W'(fwsq_pkg::QUEUE_DEPTH))
    `FWSQ_ASSERT_NEXT(a_last_ends_item, load && n_out_last, r_state == fwsq_pkg::ST_IDLE)
    `FWSQ_ASSERT_NOW(a_enqueue_only_busy, mem_we, r_busy && room)

endmodule

`default_nettype wire

// ----- tb/sv/fwsq_sb_pkg.sv -----
package fwsq_sb_pkg;

    import fwsq_pkg::*;

    // one result word as the block should report it
    typedef struct packed {
        t_kind             kind;
        logic [TIME_W-1:0] at_time;
        logic [ID_W-1:0]   subject_id;
        logic [ID_W-1:0]   next_id;
        logic              last;
    } t_queue_event;

    class t_queue_event_scoreboard;

        t_queue_event          due_events[$];
        int unsigned           errors;

        // shadow of the register and the server/queue state
        logic [CFG_W-1:0]      capacity;
        logic                  server_busy;
        logic [ID_W-1:0]       serving_id;
        logic [TIME_W-1:0]     finish_at;
        logic [ID_W+SVC_W-1:0] waiting_room [QUEUE_DEPTH];
        logic [ADDR_W-1:0]     wait_head;
        logic [CNT_W-1:0]      wait_count;

        // newest word of the item being predicted, held back until its last flag is known
        t_queue_event          held;
        bit                    have_held;

        function new();
            capacity    = CAP_RESET;
            server_busy = 1'b0;
            serving_id  = '0;
            finish_at   = '0;
            wait_head   = '0;
            wait_count  = '0;
            errors      = 0;
            have_held   = 1'b0;
        endfunction

        function void set_capacity(logic [CFG_W-1:0] value);
            capacity = value;
        endfunction

        function int pending();
            return due_events.size();
        endfunction

        // finish time with saturation at the top of the time range
        function logic [TIME_W-1:0] clamp_sum(logic [TIME_W-1:0] base, logic [SVC_W-1:0] span);
            logic [TIME_W:0] sum;
            sum = {1'b0, base} + {{(TIME_W+1-SVC_W){1'b0}}, span};
            return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        endfunction

        function void push_event(t_kind kind, logic [TIME_W-1:0] at, logic [ID_W-1:0] subj,
                                 logic [ID_W-1:0] nxt);
            if (have_held) begin
                due_events.push_back(held);
            end
            held.kind       = kind;
            held.at_time    = at;
            held.subject_id = subj;
            held.next_id    = nxt;
            held.last       = 1'b0;
            have_held       = 1'b1;
        endfunction

        // predict every result word caused by one accepted input word
        function void take_item(logic act, logic [TIME_W-1:0] t, logic [ID_W-1:0] cid,
                                logic [SVC_W-1:0] svc);
            int                    eff_cap;
            int                    retired;
            logic [ID_W+SVC_W-1:0] entry;
            eff_cap = (int'(capacity) > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(capacity);
            retired = 0;

            // retire services due by t, head waiter takes over on each finish
            while (server_busy && finish_at <= t && retired < QUEUE_DEPTH + 1) begin
                retired++;
                if (wait_count == 0) begin
                    push_event(KIND_IDLE, finish_at, serving_id, '0);
                    server_busy = 1'b0;
                end else begin
                    entry = waiting_room[wait_head];
                    push_event(KIND_NEXT, finish_at, serving_id, entry[ID_W+SVC_W-1:SVC_W]);
                    wait_head  = ADDR_W'((int'(wait_head) + 1) % QUEUE_DEPTH);
                    wait_count = wait_count - 1'b1;
                    serving_id = entry[ID_W+SVC_W-1:SVC_W];
                    finish_at  = clamp_sum(finish_at, entry[SVC_W-1:0]);
                end
            end

            // arrival: start, wait or drop
            if (act == ACT_ARRIVE) begin
                if (!server_busy) begin
                    push_event(KIND_START, t, cid, '0);
                    server_busy = 1'b1;
                    serving_id  = cid;
                    finish_at   = clamp_sum(t, svc);
                end else if (int'(wait_count) < eff_cap && int'(wait_count) < QUEUE_DEPTH) begin
                    waiting_room[(int'(wait_head) + int'(wait_count)) % QUEUE_DEPTH] = {cid, svc};
                    wait_count = wait_count + 1'b1;
                    push_event(KIND_WAIT, t, cid, '0);
                end else begin
                    push_event(KIND_DROP, t, cid, '0);
                end
            end

            if (have_held) begin
                held.last = 1'b1;
                due_events.push_back(held);
                have_held = 1'b0;
            end
        endfunction

        function void compare_field(longint stamp, string name, logic [TIME_W-1:0] want,
                                    logic [TIME_W-1:0] got);
            if (got !== want) begin
                $display("%0d ns: %s mismatch, expected %h, actual %h", stamp, name, want, got);
                errors++;
            end
        endfunction

        // compare one accepted result word with the oldest prediction
        function void match_word(longint stamp, logic [KIND_W-1:0] kind, logic [TIME_W-1:0] at,
                                 logic [ID_W-1:0] subj, logic [ID_W-1:0] nxt, logic last);
            t_queue_event want;
            if (due_events.size() == 0) begin
                $display("%0d ns: unexpected result word kind %0d at %h subject %h next %h last %b",
                         stamp, kind, at, subj, nxt, last);
                errors++;
                return;
            end
            want = due_events.pop_front();
            compare_field(stamp, "event_kind", TIME_W'(want.kind), TIME_W'(kind));
            compare_field(stamp, "at_time", want.at_time, at);
            compare_field(stamp, "subject_id", TIME_W'(want.subject_id), TIME_W'(subj));
            compare_field(stamp, "next_id", TIME_W'(want.next_id), TIME_W'(nxt));
            compare_field(stamp, "last", TIME_W'(want.last), TIME_W'(last));
        endfunction

    endclass

endpackage

// ----- tb/sv/tb_finite_wait_single_server_queue.sv -----
module tb_finite_wait_single_server_queue;

    timeunit 1ns;
    timeprecision 1ps;

    import fwsq_pkg::*;
    import fwsq_sb_pkg::*;

    localparam int STALL_LIMIT        = 4000;
    localparam int SETTLE_CYCLES      = 8;
    localparam int RANDOM_PHASE_ITEMS = 20;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_cap      = '0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic              action       = ACT_ARRIVE;
    logic [TIME_W-1:0] event_time   = '0;
    logic [ID_W-1:0]   customer_id  = '0;
    logic [SVC_W-1:0]  service_time = '0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic [KIND_W-1:0] event_kind;
    logic [TIME_W-1:0] at_time;
    logic [ID_W-1:0]   subject_id;
    logic [ID_W-1:0]   next_id;
    logic              last_flag;

    int send_idle_pct = 33;
    int recv_idle_pct = 87;

    t_queue_event_scoreboard sb;

    finite_wait_single_server_queue DUT (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_cfg_valid            (cfg_valid),
        .o_cfg_ready            (cfg_ready),
        .i_cfg_waiting_capacity (cfg_cap),
        .i_in_valid             (in_valid),
        .o_in_ready             (in_ready),
        .i_action               (action),
        .i_event_time           (event_time),
        .i_customer_id          (customer_id),
        .i_service_time         (service_time),
        .o_out_valid            (out_valid),
        .i_out_ready            (out_ready),
        .o_event_kind           (event_kind),
        .o_at_time              (at_time),
        .o_subject_id           (subject_id),
        .o_next_id              (next_id),
        .o_last                 (last_flag)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side back-pressure
    initial begin
        forever begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // handshake monitors feed the scoreboard
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                sb.take_item(action, event_time, customer_id, service_time);
            end
            if (out_valid && out_ready) begin
                sb.match_word($time, event_kind, at_time, subject_id, next_id, last_flag);
            end
            if (cfg_valid && cfg_ready) begin
                sb.set_capacity(cfg_cap);
            end
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        int stall;
        stall = 0;
        @(posedge rst_n);
        while (stall < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
                stall = 0;
            end else begin
                stall++;
            end
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // present one input word, return at the falling edge after it is taken
    task automatic send_word(logic act, logic [TIME_W-1:0] t, logic [ID_W-1:0] cid,
                             logic [SVC_W-1:0] svc);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        event_time   <= t;
        customer_id  <= cid;
        service_time <= svc;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // wait for every predicted word, then let a silent item finish inside the block
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(int value);
        settle();
        cfg_cap   <= CFG_W'(value);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly forward-moving traffic, with equal times, long jumps and a few steps back
    task automatic run_random_phase(int items);
        logic [TIME_W-1:0] now_t;
        logic [TIME_W-1:0] evt;
        logic [SVC_W-1:0]  svc;
        logic              act;
        int                r;
        int                back;
        now_t = $urandom_range(32'hFFF0_0000, 0);
        for (int k = 0; k < items; k++) begin
            r = $urandom_range(99);
            if (r < 10) begin
                now_t = now_t;
            end else if (r < 70) begin
                now_t = now_t + $urandom_range(1, 8);
            end else if (r < 90) begin
                now_t = now_t + $urandom_range(9, 80);
            end else begin
                now_t = now_t + $urandom_range(81, 5000);
            end
            evt = now_t;
            if ($urandom_range(99) < 5) begin
                back = $urandom_range(1, 50);
                evt  = (now_t > TIME_W'(back)) ? now_t - TIME_W'(back) : '0;
            end
            act = ($urandom_range(99) < 20) ? ACT_ADVANCE : ACT_ARRIVE;
            r = $urandom_range(99);
            if (r < 60) begin
                svc = SVC_W'($urandom_range(0, 12));
            end else if (r < 90) begin
                svc = SVC_W'($urandom_range(13, 200));
            end else begin
                svc = SVC_W'($urandom);
            end
            send_word(act, evt, ID_W'($urandom), svc);
        end
        // flush everything still in service or waiting
        send_word(ACT_ADVANCE, TIME_MAX, ID_W'($urandom), SVC_W'($urandom));
    endtask

    initial begin
        int phase_caps [6];
        sb = new();
        phase_caps = '{1, 0, 16, 0, 31, 3};

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // reset capacity, nothing due, equal times, time going back, saturation
        send_word(ACT_ADVANCE, 32'd10, 16'hA5A5, 16'h5A5A);
        send_word(ACT_ARRIVE, 32'd10, 16'hFFFF, 16'h0000);
        send_word(ACT_ARRIVE, 32'd10, 16'h0000, 16'd5);
        send_word(ACT_ARRIVE, 32'd12, 16'h1234, 16'd3);
        send_word(ACT_ARRIVE, 32'd11, 16'h2222, 16'hFFFF);
        send_word(ACT_ARRIVE, 32'hFFFF_FFF0, 16'h3333, 16'hFFFF);
        send_word(ACT_ADVANCE, TIME_MAX, 16'h0F0F, 16'hF0F0);

        // capacity above depth, full waiting area, then lowered below occupancy
        write_capacity(31);
        send_word(ACT_ARRIVE, 32'd100, 16'h8000, 16'd1);
        for (int k = 1; k <= QUEUE_DEPTH; k++) begin
            send_word(ACT_ARRIVE, 32'd100, ID_W'(16'h8000 + k), SVC_W'($urandom_range(0, 3)));
        end
        send_word(ACT_ARRIVE, 32'd100, 16'h80FF, 16'd9);
        write_capacity(2);
        send_word(ACT_ARRIVE, 32'd100, 16'h8100, 16'd9);
        // one arrival retires the whole queue
        send_word(ACT_ARRIVE, 32'd200000, 16'h9000, 16'd7);
        // zero capacity while busy
        write_capacity(0);
        send_word(ACT_ARRIVE, 32'd200001, 16'h9001, 16'd7);
        send_word(ACT_ADVANCE, TIME_MAX, 16'h0000, 16'h0000);

        // random phases under three idling patterns
        for (int p = 0; p < 6; p++) begin
            if (p == 2) begin
                send_idle_pct = 87;
                recv_idle_pct = 33;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_capacity((p == 1) ? int'($urandom_range(0, 31)) : phase_caps[p]);
            run_random_phase(RANDOM_PHASE_ITEMS);
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
